// ===== rtl/lkr_pkg.sv =====
`timescale 1ns / 1ps
package lkr_pkg;

  localparam int FRAME_W = 8;
  localparam int STAMP_W = 64;
  localparam int COUNT_W = 4;
  localparam int COUNT_W_MAX = 15;
  localparam int TOTAL_W = 9;

  localparam logic [1:0] FUNC_ACCESS    = 2'd0;
  localparam logic [1:0] FUNC_SET_EVICT = 2'd1;
  localparam logic [1:0] FUNC_REMOVE    = 2'd2;
  localparam logic [1:0] FUNC_EVICT     = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RANGE     = 2'd1;
  localparam logic [1:0] ST_NOT_EVICT = 2'd2;
  localparam logic [1:0] ST_NO_VICTIM = 2'd3;

  localparam logic [3:0] K_RESET = 4'd2;

  typedef struct packed {
    logic               mark;
    logic [COUNT_W-1:0] count;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic               clear;
    logic               sample;
    logic [FRAME_W-1:0] idx;
  } scan_ctl_t;

endpackage

// ===== rtl/lkr_ram.sv =====
`timescale 1ns / 1ps
module lkr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lkr_scan.sv =====
`timescale 1ns / 1ps
module lkr_scan
  import lkr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  scan_ctl_t          ctl,
  input  entry_t             ent,
  input  logic [3:0]         eff_k,
  output logic               hist_found,
  output logic [FRAME_W-1:0] hist_idx,
  output logic               cache_found,
  output logic [FRAME_W-1:0] cache_idx
);

  logic [STAMP_W-1:0] hist_stamp;
  logic [STAMP_W-1:0] cache_stamp;
  logic tracked;
  logic in_cache;

  assign tracked  = ent.count != '0;
  assign in_cache = tracked && (ent.count >= eff_k);

  // Strict less-than over ascending frames keeps the lowest frame on ties.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      hist_found  <= 1'b0;
      cache_found <= 1'b0;
    end else if (ctl.sample && tracked && ent.mark) begin
      if (in_cache) begin
        if (!cache_found || ent.stamp < cache_stamp) begin
          cache_found <= 1'b1;
        end
      end else begin
        if (!hist_found || ent.stamp < hist_stamp) begin
          hist_found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sample && tracked && ent.mark) begin
      if (in_cache) begin
        if (!cache_found || ent.stamp < cache_stamp) begin
          cache_stamp <= ent.stamp;
          cache_idx   <= ctl.idx;
        end
      end else begin
        if (!hist_found || ent.stamp < hist_stamp) begin
          hist_stamp <= ent.stamp;
          hist_idx   <= ctl.idx;
        end
      end
    end
  end

endmodule

// ===== rtl/lru_k_two_queue_replacer_top.sv =====
`timescale 1ns / 1ps
// LRU-K frame replacer. Frame state (evictable mark, access count, order
// stamp) lives in one synchronous RAM with one entry per frame; per-frame
// valid flops make unwritten entries read as untracked, so no clearing pass
// is needed after reset. Access, set evictable and remove read the entry, then
// modify it and write it back; done is registered from the modify step. Evict
// walks every RAM entry through one read port, one frame per cycle, then picks
// and clears the victim. busy is high from acceptance until the done strobe;
// done is a single-cycle pulse that the receiver must take when it appears.
module lru_k_two_queue_replacer_top
  import lkr_pkg::*;
#(
  parameter int FRAME_COUNT = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func,
  input  logic [FRAME_W-1:0] frame,
  input  logic               evictable_flag,
  output logic               done,
  output logic [1:0]         status,
  output logic [FRAME_W-1:0] victim,
  output logic [TOTAL_W-1:0] evictable_count,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_data
);

  localparam int AW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] SCAN_END = CW'(FRAME_COUNT);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_PICK = 3'd3;

  logic [2:0]         state;
  logic [3:0]         k_threshold;
  logic [3:0]         eff_k;
  logic [1:0]         op_func;
  logic [FRAME_W-1:0] op_frame;
  logic               op_flag;
  logic               op_range;
  logic [STAMP_W-1:0] access_clock;
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] total_next;
  logic [FRAME_COUNT-1:0] vld;
  logic               rd_vld;
  logic [CW-1:0]      scan_cnt;
  logic               pend;
  logic [FRAME_W-1:0] pend_idx;

  logic               accept;
  logic [AW-1:0]      raddr;
  entry_t             rdata;
  entry_t             ent;
  logic               we;
  logic [AW-1:0]      waddr;
  entry_t             wdata;
  logic [1:0]         res_status;
  logic [FRAME_W-1:0] res_victim;
  logic               res_fire;
  logic               clk_adv;

  scan_ctl_t          sctl;
  logic               hist_found;
  logic [FRAME_W-1:0] hist_idx;
  logic               cache_found;
  logic [FRAME_W-1:0] cache_idx;

  assign accept    = start && (state == S_IDLE);
  assign busy      = state != S_IDLE;
  // Take a new k only while nothing is in flight or being accepted.
  assign cfg_ready = (state == S_IDLE) && !start;
  assign eff_k     = (k_threshold == 4'd0) ? 4'd1 : k_threshold;

  assign raddr = (state == S_SCAN) ? scan_cnt[AW-1:0] : frame[AW-1:0];
  assign ent   = rd_vld ? rdata : '0;

  lkr_ram #(.WIDTH($bits(entry_t)), .DEPTH(FRAME_COUNT)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign sctl.clear  = accept;
  assign sctl.sample = pend;
  assign sctl.idx    = pend_idx;

  lkr_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .ctl         (sctl),
    .ent         (ent),
    .eff_k       (eff_k),
    .hist_found  (hist_found),
    .hist_idx    (hist_idx),
    .cache_found (cache_found),
    .cache_idx   (cache_idx)
  );

  // Modify step for the single-frame requests and the evict write-back.
  always_comb begin
    we         = 1'b0;
    waddr      = op_frame[AW-1:0];
    wdata      = ent;
    total_next = total;
    res_status = ST_OK;
    res_victim = '0;
    res_fire   = 1'b0;
    clk_adv    = 1'b0;
    if (state == S_EXEC) begin
      res_fire = 1'b1;
      if (op_range) begin
        res_status = ST_RANGE;
      end else begin
        case (op_func)
          FUNC_ACCESS: begin
            we      = 1'b1;
            clk_adv = 1'b1;
            if (ent.count == '0) begin
              wdata.count = COUNT_W'(1);
              wdata.stamp = access_clock;
            end else if (ent.count != COUNT_W'(COUNT_W_MAX)) begin
              wdata.count = ent.count + COUNT_W'(1);
            end
            if (wdata.count >= eff_k) begin
              wdata.stamp = access_clock;
            end
          end
          FUNC_SET_EVICT: begin
            we         = 1'b1;
            wdata.mark = op_flag;
            if (!ent.mark && op_flag) begin
              total_next = total + TOTAL_W'(1);
            end else if (ent.mark && !op_flag) begin
              total_next = total - TOTAL_W'(1);
            end
          end
          FUNC_REMOVE: begin
            if (ent.count != '0) begin
              if (!ent.mark) begin
                res_status = ST_NOT_EVICT;
              end else begin
                we          = 1'b1;
                wdata.count = '0;
                wdata.mark  = 1'b0;
                total_next  = total - TOTAL_W'(1);
              end
            end
          end
          default: ;
        endcase
      end
    end else if (state == S_PICK) begin
      res_fire = 1'b1;
      if (hist_found || cache_found) begin
        res_victim  = hist_found ? hist_idx : cache_idx;
        we          = 1'b1;
        waddr       = res_victim[AW-1:0];
        wdata.mark  = 1'b0;
        wdata.count = '0;
        total_next  = total - TOTAL_W'(1);
      end else begin
        res_status = ST_NO_VICTIM;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      k_threshold  <= K_RESET;
      access_clock <= '0;
      total        <= '0;
      vld          <= '0;
      done         <= 1'b0;
      pend         <= 1'b0;
      scan_cnt     <= '0;
    end else begin
      done  <= res_fire;
      total <= total_next;
      pend  <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        k_threshold <= cfg_data;
      end
      if (clk_adv) begin
        access_clock <= access_clock + STAMP_W'(1);
      end
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            scan_cnt <= '0;
            state    <= (func == FUNC_EVICT) ? S_SCAN : S_EXEC;
          end
        end
        S_EXEC: state <= S_IDLE;
        S_SCAN: begin
          // Issue one read per cycle; its data is sampled in the cycle after.
          if (scan_cnt != SCAN_END) begin
            pend     <= 1'b1;
            scan_cnt <= scan_cnt + CW'(1);
          end else begin
            state <= S_PICK;
          end
        end
        S_PICK: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_vld   <= vld[raddr];
    pend_idx <= FRAME_W'(scan_cnt[AW-1:0]);
    if (accept) begin
      op_func  <= func;
      op_frame <= frame;
      op_flag  <= evictable_flag;
      op_range <= (func != FUNC_EVICT) && (32'(frame) >= FRAME_COUNT);
    end
    if (res_fire) begin
      status <= res_status;
      victim <= res_victim;
    end
  end

  assign evictable_count = total;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy) else $error("accepted request did not raise busy");
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy || $past(state == S_EXEC || state == S_PICK))
    else $error("done strobe without a finishing step");
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !we) else $error("RAM write while idle");
  a_total_range: assert property (@(posedge clk) disable iff (rst)
    32'(total) <= FRAME_COUNT) else $error("evictable total exceeds frame count");

endmodule

// ===== verif/lru_k_two_queue_replacer_top_tb.sv =====
`timescale 1ns / 1ps
module lru_k_two_queue_replacer_top_tb;
  import lkr_pkg::*;

  localparam int NF = 64;
  localparam int DUE_DEPTH = 16;

  typedef struct {
    logic [1:0]         status;
    logic [FRAME_W-1:0] victim;
    logic [TOTAL_W-1:0] evictable_count;
  } reply_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         func = FUNC_ACCESS;
  logic [FRAME_W-1:0] frame = '0;
  logic               evictable_flag = 1'b0;
  logic               done;
  logic [1:0]         status;
  logic [FRAME_W-1:0] victim;
  logic [TOTAL_W-1:0] evictable_count;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [3:0]         cfg_data = '0;

  lru_k_two_queue_replacer_top #(.FRAME_COUNT(NF)) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .frame(frame), .evictable_flag(evictable_flag), .done(done),
    .status(status), .victim(victim), .evictable_count(evictable_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Shadow of the replacer state
  logic [3:0]  hits [NF];
  logic        marked [NF];
  logic [63:0] stamp [NF];
  logic [63:0] tick;
  int          marked_total;
  logic [3:0]  k_cur;

  reply_t replies_due [DUE_DEPTH];
  int     due_wr = 0;
  int     due_rd = 0;
  int     mismatches = 0;

  initial forever #5 clk = ~clk;

  function automatic logic cached(int f);
    logic [3:0] ke;
    ke = (k_cur == 0) ? 4'd1 : k_cur;
    return hits[f] != 0 && hits[f] >= ke;
  endfunction

  function automatic int oldest_victim(logic want_cache);
    int best;
    best = -1;
    for (int f = 0; f < NF; f++) begin
      if (hits[f] != 0 && marked[f] && cached(f) == want_cache) begin
        if (best < 0 || stamp[f] < stamp[best]) best = f;
      end
    end
    return best;
  endfunction

  function automatic void drop_frame(int f);
    hits[f] = '0;
    if (marked[f]) begin
      marked[f] = 1'b0;
      marked_total--;
    end
  endfunction

  function automatic reply_t predict_reply(logic [1:0] fn, logic [7:0] fr, logic fl);
    reply_t r;
    int v;
    r.status = ST_OK;
    r.victim = '0;
    if (fn != FUNC_EVICT && fr >= NF) begin
      r.status = ST_RANGE;
    end else if (fn == FUNC_ACCESS) begin
      if (hits[fr] == 0) begin
        hits[fr] = 4'd1;
        stamp[fr] = tick;
      end else if (hits[fr] < 15) begin
        hits[fr]++;
      end
      if (cached(fr)) stamp[fr] = tick;
      tick++;
    end else if (fn == FUNC_SET_EVICT) begin
      if (!marked[fr] && fl) marked_total++;
      else if (marked[fr] && !fl) marked_total--;
      marked[fr] = fl;
    end else if (fn == FUNC_REMOVE) begin
      if (hits[fr] != 0) begin
        if (!marked[fr]) r.status = ST_NOT_EVICT;
        else drop_frame(fr);
      end
    end else begin
      v = oldest_victim(1'b0);
      if (v < 0) v = oldest_victim(1'b1);
      if (v < 0) begin
        r.status = ST_NO_VICTIM;
      end else begin
        r.victim = v[7:0];
        drop_frame(v);
      end
    end
    r.evictable_count = marked_total[TOTAL_W-1:0];
    return r;
  endfunction

  // Check every done strobe against the oldest prediction
  always @(posedge clk) begin
    reply_t e;
    if (!rst && done) begin
      if (due_wr == due_rd) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result status=%0d", status);
      end else begin
        e = replies_due[due_rd % DUE_DEPTH];
        due_rd++;
        if (status !== e.status || victim !== e.victim ||
            evictable_count !== e.evictable_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d v=%0d cnt=%0d got st=%0d v=%0d cnt=%0d",
                     e.status, e.victim, e.evictable_count,
                     status, victim, evictable_count);
        end
      end
    end
  end

  int burst_left = 0;

  task automatic send_request(logic [1:0] fn, logic [7:0] fr, logic fl);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 20)) @(posedge clk);
    end
    burst_left--;
    start <= 1'b1;
    func <= fn;
    frame <= fr;
    evictable_flag <= fl;
    @(posedge clk);
    while (busy) @(posedge clk);
    // transaction accepted at this edge
    replies_due[due_wr % DUE_DEPTH] = predict_reply(fn, fr, fl);
    due_wr++;
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_replies();
    while (due_wr != due_rd) @(posedge clk);
    repeat (NF + 8) @(posedge clk);
  endtask

  task automatic write_k(logic [3:0] kv);
    drain_replies();
    cfg_valid <= 1'b1;
    cfg_data <= kv;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    k_cur = kv;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_directed();
    send_request(FUNC_EVICT, 8'd0, 1'b0);
    send_request(FUNC_ACCESS, 8'd255, 1'b1);
    send_request(FUNC_SET_EVICT, 8'd64, 1'b1);
    send_request(FUNC_REMOVE, 8'd200, 1'b0);
    send_request(FUNC_ACCESS, 8'd0, 1'b0);
    send_request(FUNC_ACCESS, 8'd63, 1'b0);
    send_request(FUNC_ACCESS, 8'd63, 1'b0);
    send_request(FUNC_REMOVE, 8'd0, 1'b0);
    send_request(FUNC_SET_EVICT, 8'd5, 1'b1);
    send_request(FUNC_REMOVE, 8'd5, 1'b0);
    send_request(FUNC_EVICT, 8'd0, 1'b0);
    send_request(FUNC_SET_EVICT, 8'd0, 1'b1);
    send_request(FUNC_SET_EVICT, 8'd63, 1'b1);
    send_request(FUNC_EVICT, 8'hff, 1'b1);
    send_request(FUNC_EVICT, 8'd0, 1'b0);
    send_request(FUNC_EVICT, 8'd0, 1'b0);
    send_request(FUNC_SET_EVICT, 8'd5, 1'b0);
    send_request(FUNC_SET_EVICT, 8'd5, 1'b0);
  endtask

  task automatic test_extremes_of_k();
    write_k(4'd1);
    send_request(FUNC_ACCESS, 8'd10, 1'b0);
    send_request(FUNC_ACCESS, 8'd11, 1'b0);
    send_request(FUNC_SET_EVICT, 8'd11, 1'b1);
    send_request(FUNC_SET_EVICT, 8'd10, 1'b1);
    send_request(FUNC_EVICT, 8'd0, 1'b0);
    write_k(4'd0);
    send_request(FUNC_ACCESS, 8'd12, 1'b0);
    send_request(FUNC_EVICT, 8'd0, 1'b0);
    write_k(4'd15);
    repeat (16) send_request(FUNC_ACCESS, 8'd20, 1'b0);
    send_request(FUNC_SET_EVICT, 8'd20, 1'b1);
    send_request(FUNC_REMOVE, 8'd20, 1'b0);
  endtask

  task automatic test_random_traffic(int n, int span);
    int r;
    logic [7:0] fr;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      fr = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, span - 1));
      if (r < 45) send_request(FUNC_ACCESS, fr, 1'($urandom));
      else if (r < 75) send_request(FUNC_SET_EVICT, fr, $urandom_range(0, 3) != 0);
      else if (r < 85) send_request(FUNC_REMOVE, fr, 1'($urandom));
      else send_request(FUNC_EVICT, 8'($urandom), 1'($urandom));
    end
  endtask

  task automatic test_random_k();
    logic [3:0] ks [5] = '{4'd2, 4'd1, 4'd15, 4'd3, 4'd0};
    foreach (ks[j]) begin
      write_k(ks[j]);
      test_random_traffic(200, (j % 2 == 0) ? 12 : NF);
    end
    write_k(4'($urandom));
    test_random_traffic(100, 8);
  endtask

  initial begin
    for (int f = 0; f < NF; f++) begin
      hits[f] = '0;
      marked[f] = 1'b0;
      stamp[f] = '0;
    end
    tick = '0;
    marked_total = 0;
    k_cur = K_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_extremes_of_k();
    test_random_k();
    drain_replies();
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
